[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scp assertion failed");

// next-cycle implication, off during reset
`define SCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scp assertion failed");

// next-cycle implication, checked through reset as well
`define SCP_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scp reset assertion failed");

`endif

[hdl/scp_pkg.sv]
package scp_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int PATTERN_LIMIT = 64;
  localparam int KEY_WIDTH     = 16;

  localparam int KEY_W   = 16;
  localparam int DEPTH_W = 6;
  localparam int PLANE_W = 5;
  localparam int COORD_W = 11;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 13;

  localparam int TAB_AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int PAT_W     = $clog2(PATTERN_LIMIT + 1);
  localparam int PSUM_W    = ((PAT_W > DEPTH_W) ? PAT_W : DEPTH_W) + 1;
  localparam int KEY_CMP_W = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int CLIP_LO  = -32;
  localparam int Y_LIMIT  = 212;
  localparam int Y_AVOID  = 216;
  localparam int Y_SUBST  = 217;
  localparam int X_LIMIT  = 256;
  localparam int EC_SHIFT = 32;
  localparam int BASE_SH  = 2;

  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_PLACE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CLS_CLEAR,
    CLS_LOOKUP,
    CLS_FOLLOW
  } cls_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGNIFIED = 1'b0,
    CFG_VSCROLL   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } st_t;

  typedef struct packed {
    cls_t               cls;
    logic [KEY_W-1:0]   cel_key;
    logic [DEPTH_W-1:0] cel_depth;
    logic [PLANE_W-1:0] plane_slot;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [BYTE_W-1:0]  offset_x;
    logic [BYTE_W-1:0]  offset_y;
    logic [BYTE_W-1:0]  pattern_in_cel;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               needs_load;
    logic [BYTE_W-1:0]  base_pattern;
    logic [PLANE_W-1:0] plane_out;
    logic [BYTE_W-1:0]  sprite_y;
    logic [BYTE_W-1:0]  sprite_x;
    logic [BYTE_W-1:0]  sprite_pattern;
    logic               early_clock;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t head;
  } queue_head_t;

endpackage

[hdl/scp_if.sv]
interface scp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic                        first_plane;
  logic [scp_pkg::KEY_W-1:0]   cel_key;
  logic [scp_pkg::DEPTH_W-1:0] cel_depth;
  logic [scp_pkg::PLANE_W-1:0] plane_slot;
  logic signed [scp_pkg::COORD_W-1:0] origin_x;
  logic signed [scp_pkg::COORD_W-1:0] origin_y;
  logic [scp_pkg::BYTE_W-1:0]  offset_x;
  logic [scp_pkg::BYTE_W-1:0]  offset_y;
  logic [scp_pkg::BYTE_W-1:0]  pattern_in_cel;

  modport source (
    output valid, op, first_plane, cel_key, cel_depth, plane_slot,
           origin_x, origin_y, offset_x, offset_y, pattern_in_cel,
    input  ready
  );
  modport sink (
    input  valid, op, first_plane, cel_key, cel_depth, plane_slot,
           origin_x, origin_y, offset_x, offset_y, pattern_in_cel,
    output ready
  );
endinterface

interface scp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        needs_load;
  logic [scp_pkg::BYTE_W-1:0]  base_pattern;
  logic [scp_pkg::PLANE_W-1:0] plane_out;
  logic [scp_pkg::BYTE_W-1:0]  sprite_y;
  logic [scp_pkg::BYTE_W-1:0]  sprite_x;
  logic [scp_pkg::BYTE_W-1:0]  sprite_pattern;
  logic                        early_clock;

  modport source (
    output valid, accepted, needs_load, base_pattern, plane_out,
           sprite_y, sprite_x, sprite_pattern, early_clock,
    input  ready
  );
  modport sink (
    input  valid, accepted, needs_load, base_pattern, plane_out,
           sprite_y, sprite_x, sprite_pattern, early_clock,
    output ready
  );
endinterface

interface scp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [scp_pkg::CFG_IDX_W-1:0]  index;
  logic [scp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/scp_front.sv]
module scp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  scp_in_if.sink               in_ch,
  input  logic                 q_pop,
  output scp_pkg::queue_head_t q_out
);

  scp_pkg::item_t              q_mem [scp_pkg::QUEUE_DEPTH];
  logic [scp_pkg::QA_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [scp_pkg::QA_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [scp_pkg::QC_W-1:0]    cnt_r, cnt_nxt;
  logic                        push;
  logic                        pop;
  scp_pkg::item_t              item;

  always_comb begin
    item.cel_key        = in_ch.cel_key;
    item.cel_depth      = in_ch.cel_depth;
    item.plane_slot     = in_ch.plane_slot;
    item.origin_x       = in_ch.origin_x;
    item.origin_y       = in_ch.origin_y;
    item.offset_x       = in_ch.offset_x;
    item.offset_y       = in_ch.offset_y;
    item.pattern_in_cel = in_ch.pattern_in_cel;
    if (in_ch.op == scp_pkg::OP_CLEAR) begin
      item.cls = scp_pkg::CLS_CLEAR;
    end else if (in_ch.first_plane) begin
      item.cls = scp_pkg::CLS_LOOKUP;
    end else begin
      item.cls = scp_pkg::CLS_FOLLOW;
    end
  end

  assign in_ch.ready = (cnt_r != scp_pkg::QC_W'(scp_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item;
    end
  end

  assign q_out.valid = (cnt_r != '0);
  assign q_out.head  = q_mem[rd_ptr_r];

endmodule

[hdl/scp_back.sv]
module scp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scp_pkg::queue_head_t q_in,
  output logic                 q_pop,
  scp_out_if.source            out_ch,
  scp_cfg_if.sink              cfg_ch
);

  logic [scp_pkg::KEY_CMP_W-1:0] key_mem  [scp_pkg::TABLE_ENTRIES];
  logic [scp_pkg::BYTE_W-1:0]    base_mem [scp_pkg::TABLE_ENTRIES];

  scp_pkg::st_t                  st_r, st_nxt;
  logic [scp_pkg::CNT_W-1:0]     live_r, live_nxt;
  logic [scp_pkg::PAT_W-1:0]     pat_used_r, pat_used_nxt;
  logic [scp_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic                          rd_v_r, rd_v_nxt;
  logic                          cur_valid_r, cur_valid_nxt;
  logic [scp_pkg::BYTE_W-1:0]    cur_base_r, cur_base_nxt;
  logic                          loaded_r, loaded_nxt;
  logic [scp_pkg::KEY_CMP_W-1:0] key_rd_r;
  logic [scp_pkg::BYTE_W-1:0]    base_rd_r;
  logic                          magnified_r;
  logic [scp_pkg::BYTE_W-1:0]    vscroll_r;
  logic                          out_valid_r, out_valid_nxt;
  scp_pkg::result_t              out_r, out_nxt;

  logic                          mem_re, mem_we;
  logic                          hit, fits;
  logic [scp_pkg::PSUM_W-1:0]    psum;
  logic [scp_pkg::BYTE_W-1:0]    new_base;
  logic [scp_pkg::KEY_CMP_W-1:0] key_cmp;
  scp_pkg::item_t                hd;
  scp_pkg::result_t              res;

  logic signed [scp_pkg::POS_W-1:0] offx, offy, sx, sy, sx_c, sy_c;
  logic [scp_pkg::BYTE_W-1:0]       y8, x8;
  logic                             ec;

  assign hd       = q_in.head;
  assign key_cmp  = hd.cel_key[scp_pkg::KEY_CMP_W-1:0];
  assign hit      = rd_v_r && (key_rd_r == key_cmp);
  assign psum     = scp_pkg::PSUM_W'(pat_used_r) + scp_pkg::PSUM_W'(hd.cel_depth);
  assign fits     = (live_r < scp_pkg::CNT_W'(scp_pkg::TABLE_ENTRIES)) &&
                    (psum <= scp_pkg::PSUM_W'(scp_pkg::PATTERN_LIMIT));
  assign new_base = scp_pkg::BYTE_W'({pat_used_r, {scp_pkg::BASE_SH{1'b0}}});

  // placement arithmetic on the queue head
  always_comb begin
    if (magnified_r) begin
      offx = $signed({4'b0, hd.offset_x, 1'b0});
      offy = $signed({4'b0, hd.offset_y, 1'b0});
    end else begin
      offx = $signed({5'b0, hd.offset_x});
      offy = $signed({5'b0, hd.offset_y});
    end
    sx = $signed({{2{hd.origin_x[scp_pkg::COORD_W-1]}}, hd.origin_x}) + offx;
    sy = $signed({{2{hd.origin_y[scp_pkg::COORD_W-1]}}, hd.origin_y}) + offy;

    sy_c = sy;
    if (sy < scp_pkg::CLIP_LO || sy >= scp_pkg::Y_LIMIT) begin
      sy_c = scp_pkg::POS_W'(scp_pkg::CLIP_LO);
    end
    y8 = sy_c[scp_pkg::BYTE_W-1:0] - 8'd1 + vscroll_r;
    if (y8 == scp_pkg::BYTE_W'(scp_pkg::Y_AVOID)) begin
      y8 = scp_pkg::BYTE_W'(scp_pkg::Y_SUBST);
    end

    sx_c = sx;
    if (sx < scp_pkg::CLIP_LO || sx >= scp_pkg::X_LIMIT) begin
      sx_c = scp_pkg::POS_W'(scp_pkg::CLIP_LO);
    end
    ec = sx_c[scp_pkg::POS_W-1];
    x8 = sx_c[scp_pkg::BYTE_W-1:0];
    if (ec) begin
      x8 = x8 + scp_pkg::BYTE_W'(scp_pkg::EC_SHIFT);
    end

    res = '0;
    if (hd.cls != scp_pkg::CLS_CLEAR) begin
      res.plane_out = hd.plane_slot;
      if (cur_valid_r) begin
        res.accepted       = 1'b1;
        res.needs_load     = loaded_r;
        res.base_pattern   = cur_base_r;
        res.sprite_y       = y8;
        res.sprite_x       = x8;
        res.sprite_pattern = hd.pattern_in_cel + cur_base_r;
        res.early_clock    = ec;
      end
    end
  end

  always_comb begin
    st_nxt        = st_r;
    live_nxt      = live_r;
    pat_used_nxt  = pat_used_r;
    idx_nxt       = idx_r;
    rd_v_nxt      = 1'b0;
    cur_valid_nxt = cur_valid_r;
    cur_base_nxt  = cur_base_r;
    loaded_nxt    = loaded_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    q_pop         = 1'b0;
    case (st_r)
      scp_pkg::ST_IDLE: begin
        if (q_in.valid) begin
          loaded_nxt = 1'b0;
          if (hd.cls == scp_pkg::CLS_LOOKUP) begin
            idx_nxt = '0;
            st_nxt  = scp_pkg::ST_SEARCH;
          end else begin
            st_nxt = scp_pkg::ST_EMIT;
          end
        end
      end
      scp_pkg::ST_SEARCH: begin
        if (hit) begin
          cur_valid_nxt = 1'b1;
          cur_base_nxt  = base_rd_r;
          loaded_nxt    = 1'b0;
          st_nxt        = scp_pkg::ST_EMIT;
        end else if (idx_r < live_r) begin
          mem_re   = 1'b1;
          rd_v_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end else begin
          st_nxt = scp_pkg::ST_EMIT;
          if (fits) begin
            mem_we        = 1'b1;
            pat_used_nxt  = scp_pkg::PAT_W'(psum);
            live_nxt      = live_r + 1'b1;
            cur_valid_nxt = 1'b1;
            cur_base_nxt  = new_base;
            loaded_nxt    = 1'b1;
          end else begin
            cur_valid_nxt = 1'b0;
            loaded_nxt    = 1'b0;
          end
        end
      end
      scp_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res;
          out_valid_nxt = 1'b1;
          q_pop         = 1'b1;
          st_nxt        = scp_pkg::ST_IDLE;
          if (hd.cls == scp_pkg::CLS_CLEAR) begin
            live_nxt      = '0;
            pat_used_nxt  = '0;
            cur_valid_nxt = 1'b0;
          end
        end
      end
      default: begin
        st_nxt = scp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= scp_pkg::ST_IDLE;
      live_r      <= '0;
      pat_used_r  <= '0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      cur_valid_r <= 1'b0;
      cur_base_r  <= '0;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      magnified_r <= 1'b0;
      vscroll_r   <= '0;
    end else begin
      st_r        <= st_nxt;
      live_r      <= live_nxt;
      pat_used_r  <= pat_used_nxt;
      idx_r       <= idx_nxt;
      rd_v_r      <= rd_v_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_base_r  <= cur_base_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          scp_pkg::CFG_MAGNIFIED: magnified_r <= cfg_ch.data[0];
          scp_pkg::CFG_VSCROLL:   vscroll_r   <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[live_r[scp_pkg::TAB_AW-1:0]]  <= key_cmp;
      base_mem[live_r[scp_pkg::TAB_AW-1:0]] <= new_base;
    end
    if (mem_re) begin
      key_rd_r  <= key_mem[idx_r[scp_pkg::TAB_AW-1:0]];
      base_rd_r <= base_mem[idx_r[scp_pkg::TAB_AW-1:0]];
    end
  end

  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_r.accepted;
  assign out_ch.needs_load     = out_r.needs_load;
  assign out_ch.base_pattern   = out_r.base_pattern;
  assign out_ch.plane_out      = out_r.plane_out;
  assign out_ch.sprite_y       = out_r.sprite_y;
  assign out_ch.sprite_x       = out_r.sprite_x;
  assign out_ch.sprite_pattern = out_r.sprite_pattern;
  assign out_ch.early_clock    = out_r.early_clock;

endmodule

[hdl/sprite_cel_placer.sv]
// channel  dir  handshake      beat
// in_ch    in   valid/ready    one plane item or one table clear
// out_ch   out  valid/ready    one placed sprite result
// cfg_ch   in   valid/ready    register write: index, data (ready held high)
//
// Clear and non-first planes go from idle straight to the emit state in the
// placer; a first plane first runs the one-entry-per-cycle key search through
// the table memory. A two-beat queue sits in front of the placer.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// A stalled out_ch holds the result register and backs up into the queue.
module sprite_cel_placer (
  input  logic      clk,
  input  logic      rst_n,
  scp_in_if.sink    in_ch,
  scp_out_if.source out_ch,
  scp_cfg_if.sink   cfg_ch
);

  scp_pkg::queue_head_t q_head;
  logic                 q_pop;

  scp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_pop (q_pop),
    .q_out (q_head)
  );

  scp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_in   (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

[hdl/scp_chk.sv]
`include "assert_macros.svh"

module scp_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        accepted,
  input logic                        needs_load,
  input logic [scp_pkg::BYTE_W-1:0]  base_pattern,
  input logic [scp_pkg::BYTE_W-1:0]  sprite_y,
  input logic [scp_pkg::BYTE_W-1:0]  sprite_x,
  input logic [scp_pkg::BYTE_W-1:0]  sprite_pattern,
  input logic                        early_clock
);

  `SCP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sprite_y) && $stable(sprite_x) && $stable(accepted))
  `SCP_ASSERT_IMP(a_y_avoid, out_valid, sprite_y != scp_pkg::BYTE_W'(scp_pkg::Y_AVOID))
  `SCP_ASSERT_IMP(a_reject_zero, out_valid && !accepted, !needs_load && !early_clock && sprite_x == '0 && sprite_y == '0 && sprite_pattern == '0 && base_pattern == '0)
  `SCP_ASSERT_IMP(a_load_base, out_valid && needs_load, accepted && base_pattern[1:0] == 2'b00)
  `SCP_ASSERT_RST(a_rst_idle, !rst_n, !out_valid)

endmodule

bind sprite_cel_placer scp_chk u_scp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .accepted       (out_ch.accepted),
  .needs_load     (out_ch.needs_load),
  .base_pattern   (out_ch.base_pattern),
  .sprite_y       (out_ch.sprite_y),
  .sprite_x       (out_ch.sprite_x),
  .sprite_pattern (out_ch.sprite_pattern),
  .early_clock    (out_ch.early_clock)
);
